@@ rtl/lzfu_pkg.sv @@
package lzfu_pkg;

	localparam int DICT_AW = 12;
	localparam int DICT_DEPTH = 1 << DICT_AW;
	localparam int LIMIT_W = 24;
	localparam int PRESET_LEN = 207;

	// Result kinds carried on the master-side tuser.
	localparam logic [1:0] ST_DATA = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_CORRUPT = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} lzfu_result_t;

	// Preset dictionary text; the first character sits in the top byte.
	localparam logic [8*PRESET_LEN-1:0] PRESET_TEXT = {
		"{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
		"{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscrip",
		"t \\fdecor MS Sans SerifSymbolArialTimes Ne",
		"w RomanCourier{\\colortbl\\red0\\green0\\blue0",
		"\015\012\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab",
		"\\tx"
	};

	// Byte of the preset text at a dictionary address below PRESET_LEN.
	function automatic logic [7:0] preset_byte(input logic [7:0] addr);
		logic [7:0]  idx;
		logic [10:0] bitpos;
		idx = 8'(PRESET_LEN - 1) - addr;
		bitpos = {idx, 3'b000};
		return PRESET_TEXT[bitpos +: 8];
	endfunction

endpackage

@@ rtl/lzfu_ram.sv @@
module lzfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/lzfu_core.sv @@
module lzfu_core
	import lzfu_pkg::*;
#(
	parameter int OUT_COUNT_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          in_byte,
	input  logic                msg_start,
	input  logic                in_last,
	output logic                in_ready,
	input  logic                out_free,
	output logic                res_valid,
	output lzfu_result_t        res,
	input  logic [LIMIT_W-1:0]  output_limit,
	output logic                ram_we,
	output logic [DICT_AW-1:0]  ram_waddr,
	output logic [7:0]          ram_wdata,
	output logic                ram_re,
	output logic [DICT_AW-1:0]  ram_raddr,
	input  logic [7:0]          ram_rdata
);

	localparam int CMP_W = (OUT_COUNT_BITS > LIMIT_W) ? OUT_COUNT_BITS : LIMIT_W;
	localparam logic [OUT_COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [DICT_AW:0] FILL_MAX = (DICT_AW + 1)'(DICT_DEPTH);
	localparam logic [DICT_AW-1:0] WP_RESET = DICT_AW'(PRESET_LEN);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_LIT = 3'd2;
	localparam logic [2:0] S_COPY_RD = 3'd3;
	localparam logic [2:0] S_COPY_EM = 3'd4;
	localparam logic [2:0] S_END_ZERO = 3'd5;
	localparam logic [2:0] S_END_OK = 3'd6;
	localparam logic [2:0] S_TAIL = 3'd7;

	localparam logic [1:0] PH_CONTROL = 2'd0;
	localparam logic [1:0] PH_ITEM = 2'd1;
	localparam logic [1:0] PH_REF_LOW = 2'd2;
	localparam logic [1:0] PH_STOPPED = 2'd3;

	logic [2:0]                seq_q;
	logic [1:0]                phase_q;
	logic [7:0]                flags_q;
	logic [2:0]                flag_idx_q;
	logic [7:0]                ref_high_q;
	logic [DICT_AW-1:0]        wp_q;
	logic [DICT_AW:0]          fill_q;
	logic [OUT_COUNT_BITS-1:0] count_q;
	logic [7:0]                prev_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic [DICT_AW-1:0]        addr_q;
	logic [4:0]                rem_q;
	logic                      hit_q;
	logic [7:0]                pre_q;

	logic                      over;
	logic [DICT_AW-1:0]        ref_offset;
	logic [DICT_AW-1:0]        rel_addr;
	logic [7:0]                copy_byte;
	logic                      emit_step;
	logic [7:0]                emit_byte;

	assign in_ready = (seq_q == S_IDLE);
	assign over = CMP_W'(count_q) > CMP_W'(output_limit);
	assign ref_offset = {ref_high_q, byte_q[7:4]};
	assign rel_addr = addr_q - WP_RESET;
	assign copy_byte = hit_q ? ram_rdata : pre_q;

	// A data byte goes into the dictionary whenever it is emitted from a literal or a copy.
	assign emit_step = out_free && !over && ((seq_q == S_LIT) || (seq_q == S_COPY_EM));
	assign emit_byte = (seq_q == S_LIT) ? byte_q : copy_byte;

	assign ram_we = emit_step;
	assign ram_waddr = wp_q;
	assign ram_wdata = emit_byte;
	assign ram_re = (seq_q == S_COPY_RD);
	assign ram_raddr = addr_q;

	always_comb begin
		res_valid = 1'b0;
		res = '{data: 8'h00, status: ST_DATA, last: 1'b0};
		unique case (seq_q)
			S_LIT, S_COPY_EM: begin
				res_valid = out_free;
				if (over) begin
					res = '{data: 8'h00, status: ST_CORRUPT, last: 1'b1};
				end else begin
					res.data = emit_byte;
					res.last = ((seq_q == S_LIT) || (rem_q == 5'd0)) && !last_q;
				end
			end
			S_END_ZERO: begin
				res_valid = out_free;
			end
			S_END_OK: begin
				res_valid = out_free;
				res = '{data: 8'h00, status: ST_DONE, last: 1'b1};
			end
			S_TAIL: begin
				res_valid = out_free;
				res.status = (phase_q == PH_REF_LOW) ? ST_CORRUPT : ST_DONE;
				res.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_IDLE;
			phase_q <= PH_CONTROL;
			flags_q <= '0;
			flag_idx_q <= '0;
			ref_high_q <= '0;
			wp_q <= WP_RESET;
			fill_q <= '0;
			count_q <= '0;
			prev_q <= '0;
		end else begin
			unique case (seq_q)
				S_IDLE: begin
					if (accept) begin
						seq_q <= S_DECODE;
						if (msg_start) begin
							phase_q <= PH_CONTROL;
							flags_q <= '0;
							flag_idx_q <= '0;
							ref_high_q <= '0;
							wp_q <= WP_RESET;
							fill_q <= '0;
							count_q <= '0;
							prev_q <= '0;
						end
					end
				end
				S_DECODE: begin
					unique case (phase_q)
						PH_STOPPED: begin
							seq_q <= S_IDLE;
						end
						PH_CONTROL: begin
							flags_q <= byte_q;
							flag_idx_q <= '0;
							phase_q <= PH_ITEM;
							seq_q <= last_q ? S_TAIL : S_IDLE;
						end
						PH_ITEM: begin
							if (flags_q[flag_idx_q]) begin
								ref_high_q <= byte_q;
								phase_q <= PH_REF_LOW;
								seq_q <= last_q ? S_TAIL : S_IDLE;
							end else begin
								seq_q <= S_LIT;
							end
						end
						PH_REF_LOW: begin
							if (ref_offset == wp_q) begin
								seq_q <= (prev_q != 8'h00) ? S_END_ZERO : S_END_OK;
							end else begin
								seq_q <= S_COPY_RD;
							end
						end
						default: begin
						end
					endcase
				end
				S_COPY_RD: begin
					seq_q <= S_COPY_EM;
				end
				S_LIT, S_COPY_EM: begin
					if (out_free) begin
						if (over) begin
							phase_q <= PH_STOPPED;
							seq_q <= S_IDLE;
						end else if ((seq_q == S_COPY_EM) && (rem_q != 5'd0)) begin
							seq_q <= S_COPY_RD;
						end else begin
							if (flag_idx_q == 3'd7) begin
								flag_idx_q <= '0;
								phase_q <= PH_CONTROL;
							end else begin
								flag_idx_q <= flag_idx_q + 3'd1;
								phase_q <= PH_ITEM;
							end
							seq_q <= last_q ? S_TAIL : S_IDLE;
						end
						if (!over) begin
							wp_q <= wp_q + DICT_AW'(1);
							if (fill_q != FILL_MAX) begin
								fill_q <= fill_q + (DICT_AW + 1)'(1);
							end
							if (count_q != CNT_MAX) begin
								count_q <= count_q + OUT_COUNT_BITS'(1);
							end
							prev_q <= emit_byte;
						end
					end
				end
				S_END_ZERO: begin
					if (out_free) begin
						if (count_q != CNT_MAX) begin
							count_q <= count_q + OUT_COUNT_BITS'(1);
						end
						prev_q <= 8'h00;
						seq_q <= S_END_OK;
					end
				end
				S_END_OK, S_TAIL: begin
					if (out_free) begin
						phase_q <= PH_STOPPED;
						seq_q <= S_IDLE;
					end
				end
				default: begin
					seq_q <= S_IDLE;
				end
			endcase
		end
	end

	// Input byte capture, copy address walker and its lookup of written entries versus preset text.
	always_ff @(posedge clk) begin
		if (accept && in_ready) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if ((seq_q == S_DECODE) && (phase_q == PH_REF_LOW)) begin
			addr_q <= ref_offset;
			rem_q <= {1'b0, byte_q[3:0]} + 5'd1;
		end else if ((seq_q == S_COPY_EM) && emit_step) begin
			addr_q <= addr_q + DICT_AW'(1);
			rem_q <= rem_q - 5'd1;
		end
		if (seq_q == S_COPY_RD) begin
			// Entries are written in order from the preset end, so the fill count
			// tells which ones hold message data and which still hold the preset.
			hit_q <= {1'b0, rel_addr} < fill_q;
			pre_q <= (addr_q < WP_RESET) ? preset_byte(addr_q[7:0]) : 8'h00;
		end
	end

endmodule

@@ rtl/lzfu_rtf_decompressor_unit.sv @@
// Channel   Direction  tdata          tuser          tlast
// s_axis    in         in_byte [7:0]  msg_start [0]  in_last
// m_axis    out        out_byte [7:0] status [1:0]   run_last
// cfg       in         cfg_wdata = output_limit [23:0], written when cfg_we is high
//
// A control byte or a reference high byte is decoded; a literal is decoded and
// emitted. A reference low byte copies (length) bytes, each a RAM read and then a
// write; an end marker emits a done status, after a zero byte if the last byte out
// was nonzero. A last byte that leaves the message open adds a status result. No
// clearing pass runs after reset or a message start: a fill count marks which
// entries were written, the rest read as the preset text. A stalled m_axis holds it.
module lzfu_rtf_decompressor_unit
	import lzfu_pkg::*;
#(
	parameter int OUT_COUNT_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // in_byte [7:0]
	input  logic               s_axis_tuser,   // msg_start [0]
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [7:0]         m_axis_tdata,   // out_byte [7:0]
	output logic [1:0]         m_axis_tuser,   // status [1:0]
	output logic               m_axis_tlast,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	logic [LIMIT_W-1:0] limit_q;
	logic               out_valid_q;
	lzfu_result_t       out_q;
	logic               out_free;
	logic               res_valid;
	lzfu_result_t       res;
	logic               ram_we;
	logic [DICT_AW-1:0] ram_waddr;
	logic [7:0]         ram_wdata;
	logic               ram_re;
	logic [DICT_AW-1:0] ram_raddr;
	logic [7:0]         ram_rdata;

	assign out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q.data;
	assign m_axis_tuser = out_q.status;
	assign m_axis_tlast = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	lzfu_core #(
		.OUT_COUNT_BITS(OUT_COUNT_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (s_axis_tvalid && s_axis_tready),
		.in_byte      (s_axis_tdata),
		.msg_start    (s_axis_tuser),
		.in_last      (s_axis_tlast),
		.in_ready     (s_axis_tready),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res),
		.output_limit (limit_q),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	lzfu_ram #(
		.WIDTH (8),
		.DEPTH (DICT_DEPTH)
	) u_dict (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ rtl/lzfu_checker.sv @@
module lzfu_checker
	import lzfu_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [7:0]         m_axis_tdata,
	input logic [1:0]         m_axis_tuser,
	input logic               m_axis_tlast
);

	// After an accepted transfer, input ready is low in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled output transfer changed");

	a_status_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_DATA) |-> m_axis_tdata == 8'h00)
		else $error("status result carries nonzero data");

	// Results of one input byte are still pending, so no new byte may be taken.
	a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready while a run of results is unfinished");

endmodule

bind lzfu_rtf_decompressor_unit lzfu_checker u_checker (.*);
